### rtl/bid_pkg.sv
// Package for the bytecode instruction delimiter.
// Holds phase and role codes, opcode constants, state/result types and the operand table.
// No dependencies.
`timescale 1ns / 1ps

package bid_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE   = 3'd0,
    PH_FIXED    = 3'd1,
    PH_PAD      = 3'd2,
    PH_LS_HDR   = 3'd3,
    PH_TS_HDR   = 3'd4,
    PH_ENTRY    = 3'd5,
    PH_WIDE_OP  = 3'd6,
    PH_WIDE_ARG = 3'd7
  } phase_t;

  localparam logic [2:0] ROLE_OPCODE    = 3'd0;
  localparam logic [2:0] ROLE_OPERAND   = 3'd1;
  localparam logic [2:0] ROLE_PADDING   = 3'd2;
  localparam logic [2:0] ROLE_SW_HEADER = 3'd3;
  localparam logic [2:0] ROLE_SW_ENTRY  = 3'd4;
  localparam logic [2:0] ROLE_WIDE_OP   = 3'd5;
  localparam logic [2:0] ROLE_WIDE_ARG  = 3'd6;

  localparam logic [7:0] OP_TABLESWITCH  = 8'hAA;
  localparam logic [7:0] OP_LOOKUPSWITCH = 8'hAB;
  localparam logic [7:0] OP_WIDE         = 8'hC4;
  localparam logic [7:0] OP_IINC         = 8'h84;

  localparam logic [3:0] LS_HDR_BYTES   = 4'd8;
  localparam logic [3:0] TS_HDR_BYTES   = 4'd12;
  localparam logic [3:0] TS_LOW_MARK    = 4'd4;
  localparam logic [3:0] LS_ENTRY_BYTES = 4'd8;
  localparam logic [3:0] TS_ENTRY_BYTES = 4'd4;
  localparam logic [3:0] IINC_ARG_BYTES = 4'd4;
  localparam logic [3:0] WIDE_ARG_BYTES = 4'd2;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  offset_mod_four;
    logic [3:0]  bytes_left;
    logic [31:0] word_assembly;
    logic [31:0] low_bound;
    logic [32:0] entries_left;
    logic [7:0]  opcode_held;
  } state_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic       instr_last;
    logic       format_error;
    logic [7:0] current_opcode;
  } result_t;

  function automatic logic [2:0] fixed_operands(input logic [7:0] op);
    logic [2:0] n;
    begin
      unique case (op)
        8'h10, 8'h12, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A,
        8'hA9, 8'hBC:
          n = 3'd1;
        8'h11, 8'h13, 8'h14, 8'h84,
        8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E,
        8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'hA7, 8'hA8,
        8'hB2, 8'hB3, 8'hB4, 8'hB5,
        8'hB6, 8'hB7, 8'hB8,
        8'hBB, 8'hBD, 8'hC0, 8'hC1, 8'hC6, 8'hC7:
          n = 3'd2;
        8'hC5:
          n = 3'd3;
        8'hB9, 8'hBA, 8'hC8, 8'hC9:
          n = 3'd4;
        default:
          n = 3'd0;
      endcase
      return n;
    end
  endfunction

endpackage

### rtl/bid_decode.sv
// Per-byte decode: next delimiter state and result fields for one code byte.
// Purely combinational; depends on bid_pkg.
`timescale 1ns / 1ps

module bid_decode
  import bid_pkg::*;
(
  input  logic [7:0] code_byte,
  input  logic       start_of_code,
  input  state_t     cur,
  output state_t     nxt,
  output result_t    res
);

  phase_t      ph;
  logic [1:0]  off;
  logic [3:0]  bl_dec;
  logic [31:0] word_shift;
  logic [32:0] ts_count;
  logic [32:0] ent_dec;
  logic [1:0]  pad;
  logic [2:0]  n_ops;
  logic        is_lookup_held;

  always_comb begin
    ph             = start_of_code ? PH_OPCODE : cur.phase;
    off            = start_of_code ? 2'd0 : cur.offset_mod_four;
    bl_dec         = cur.bytes_left - 4'd1;
    word_shift     = {cur.word_assembly[23:0], code_byte};
    ts_count       = {1'b0, word_shift ^ 32'h8000_0000}
                   - {1'b0, cur.low_bound ^ 32'h8000_0000} + 33'd1;
    ent_dec        = cur.entries_left - 33'd1;
    pad            = ~off;
    n_ops          = fixed_operands(code_byte);
    is_lookup_held = (cur.opcode_held == OP_LOOKUPSWITCH);

    nxt              = cur;
    nxt.phase        = ph;
    res.byte_role    = ROLE_OPCODE;
    res.instr_last   = 1'b0;
    res.format_error = 1'b0;

    unique case (ph)
      PH_FIXED: begin
        res.byte_role  = ROLE_OPERAND;
        nxt.bytes_left = bl_dec;
        if (bl_dec == 4'd0) begin
          res.instr_last = 1'b1;
          nxt.phase      = PH_OPCODE;
        end
      end
      PH_PAD: begin
        res.byte_role  = ROLE_PADDING;
        nxt.bytes_left = bl_dec;
        if (bl_dec == 4'd0) begin
          nxt.word_assembly = 32'd0;
          nxt.phase         = is_lookup_held ? PH_LS_HDR : PH_TS_HDR;
          nxt.bytes_left    = is_lookup_held ? LS_HDR_BYTES : TS_HDR_BYTES;
        end
      end
      PH_LS_HDR: begin
        res.byte_role     = ROLE_SW_HEADER;
        nxt.word_assembly = word_shift;
        nxt.bytes_left    = bl_dec;
        if (bl_dec == 4'd0) begin
          if (word_shift[31]) begin
            res.format_error = 1'b1;
            res.instr_last   = 1'b1;
            nxt.phase        = PH_OPCODE;
          end else if (word_shift == 32'd0) begin
            res.instr_last = 1'b1;
            nxt.phase      = PH_OPCODE;
          end else begin
            nxt.entries_left = {1'b0, word_shift};
            nxt.bytes_left   = LS_ENTRY_BYTES;
            nxt.phase        = PH_ENTRY;
          end
        end
      end
      PH_TS_HDR: begin
        res.byte_role     = ROLE_SW_HEADER;
        nxt.word_assembly = word_shift;
        nxt.bytes_left    = bl_dec;
        if (bl_dec == TS_LOW_MARK) begin
          nxt.low_bound = word_shift;
        end
        if (bl_dec == 4'd0) begin
          if ($signed(cur.low_bound) > $signed(word_shift)) begin
            res.format_error = 1'b1;
            res.instr_last   = 1'b1;
            nxt.phase        = PH_OPCODE;
          end else begin
            nxt.entries_left = ts_count;
            nxt.bytes_left   = TS_ENTRY_BYTES;
            nxt.phase        = PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        res.byte_role  = ROLE_SW_ENTRY;
        nxt.bytes_left = bl_dec;
        if (bl_dec == 4'd0) begin
          nxt.entries_left = ent_dec;
          if (ent_dec == 33'd0) begin
            res.instr_last = 1'b1;
            nxt.phase      = PH_OPCODE;
          end else begin
            nxt.bytes_left = is_lookup_held ? LS_ENTRY_BYTES : TS_ENTRY_BYTES;
          end
        end
      end
      PH_WIDE_OP: begin
        res.byte_role  = ROLE_WIDE_OP;
        nxt.bytes_left = (code_byte == OP_IINC) ? IINC_ARG_BYTES : WIDE_ARG_BYTES;
        nxt.phase      = PH_WIDE_ARG;
      end
      PH_WIDE_ARG: begin
        res.byte_role  = ROLE_WIDE_ARG;
        nxt.bytes_left = bl_dec;
        if (bl_dec == 4'd0) begin
          res.instr_last = 1'b1;
          nxt.phase      = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        res.byte_role   = ROLE_OPCODE;
        nxt.opcode_held = code_byte;
        if (code_byte == OP_TABLESWITCH || code_byte == OP_LOOKUPSWITCH) begin
          if (pad != 2'd0) begin
            nxt.phase      = PH_PAD;
            nxt.bytes_left = {2'b00, pad};
          end else begin
            nxt.word_assembly = 32'd0;
            if (code_byte == OP_LOOKUPSWITCH) begin
              nxt.phase      = PH_LS_HDR;
              nxt.bytes_left = LS_HDR_BYTES;
            end else begin
              nxt.phase      = PH_TS_HDR;
              nxt.bytes_left = TS_HDR_BYTES;
            end
          end
        end else if (code_byte == OP_WIDE) begin
          nxt.phase = PH_WIDE_OP;
        end else if (n_ops == 3'd0) begin
          res.instr_last = 1'b1;
          nxt.phase      = PH_OPCODE;
        end else begin
          nxt.phase      = PH_FIXED;
          nxt.bytes_left = {1'b0, n_ops};
        end
      end
      default: begin
        nxt.phase = PH_OPCODE;
      end
    endcase

    nxt.offset_mod_four = off + 2'd1;
    res.current_opcode  = nxt.opcode_held;
  end

endmodule

### rtl/bid_skid.sv
// Two-entry result buffer between the decode stage and the result channel.
// Depends on bid_pkg for the result type.
`timescale 1ns / 1ps

module bid_skid
  import bid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t head
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign result_valid = (count != 2'd0);
  assign full         = (count == 2'd2);
  assign pop          = result_valid && !result_stall;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/bytecode_instruction_delimiter_core.sv
// Bytecode instruction delimiter: one role/last/error/opcode transaction per code byte.
// Result valid once the accepted byte has passed the input register and then the result buffer.
// Throughput: 1 byte per cycle while byte_stall is low; the decode against the state register is combinational.
// Input stalls only when the two-entry result buffer is full and a byte is held.
// Reset (rst, synchronous): phase to expecting opcode, counters and words cleared,
// input register and result buffer emptied.
`timescale 1ns / 1ps

module bytecode_instruction_delimiter_core
  import bid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] code_byte,
  input  logic       start_of_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] byte_role,
  output logic       instr_last,
  output logic       format_error,
  output logic [7:0] current_opcode
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_start;
  state_t     state;
  state_t     state_next;
  result_t    dec_res;
  result_t    head;
  logic       buf_full;
  logic       fire;
  logic       accept;

  assign fire       = hold_valid && !buf_full;
  assign byte_stall = hold_valid && buf_full;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte  <= code_byte;
      hold_start <= start_of_code;
    end
  end

  bid_decode u_decode (
    .code_byte     (hold_byte),
    .start_of_code (hold_start),
    .cur           (state),
    .nxt           (state_next),
    .res           (dec_res)
  );

  // all-zero state is phase expecting opcode with counters and words cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  bid_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (fire),
    .push_data    (dec_res),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign byte_role      = head.byte_role;
  assign instr_last     = head.instr_last;
  assign format_error   = head.format_error;
  assign current_opcode = head.current_opcode;

endmodule
